// ===== design/anem_pkg.sv =====
package anem_pkg;

    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 16;
    localparam int DEB_W      = 20;
    localparam int MIN_W      = 16;
    localparam int MPR_W      = 24;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int MPH_W      = 8;
    localparam int RAW_W      = 16;
    localparam int NUM_W      = 44;
    localparam int DIV_CNT_W  = $clog2(NUM_W);
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = 1;
    localparam int Q_CNT_W    = 2;

    localparam logic [1:0] CMD_EDGE = 2'd0;
    localparam logic [1:0] CMD_READ = 2'd1;
    localparam logic [1:0] CMD_GUST = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MPH_RPS   = 8'd3;

    localparam logic [DEB_W-1:0]  DEBOUNCE_RST  = 20'd5000;
    localparam logic [TIME_W-1:0] TIMEOUT_RST   = 32'd10000000;
    localparam logic [MIN_W-1:0]  MIN_COUNT_RST = 16'd3;
    localparam logic [MPR_W-1:0]  MPH_RPS_RST   = 24'd147456;

    localparam logic [19:0]      US_PER_S = 20'd1000000;
    localparam logic [MPH_W-1:0] MPH_MAX  = 8'd255;
    localparam logic [RAW_W-1:0] RAW_MAX  = 16'hFFFF;
    localparam logic [NUM_W:0]   MPH_HALF = 45'd32768;

    typedef struct packed {
        logic [DEB_W-1:0]  debounce_us;
        logic [TIME_W-1:0] timeout_us;
        logic [MIN_W-1:0]  avg_min_pulses;
        logic [MPR_W-1:0]  mph_per_rps;
    } cfg_t;

    typedef struct packed {
        logic               is_gust;
        logic [TIME_W-1:0]  per;
        logic [COUNT_W-1:0] cnt;
        logic [TIME_W-1:0]  span;
        logic [TIME_W-1:0]  silence;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  dividend;
        logic [TIME_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_AVG,
        B_QUO,
        B_DONE
    } back_state_t;

endpackage

// ===== design/anem_in_if.sv =====
interface anem_in_if;
    import anem_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        cmd;
    logic [TIME_W-1:0] time_us;

    modport source (output valid, output cmd, output time_us, input ready);
    modport sink (input valid, input cmd, input time_us, output ready);
endinterface

// ===== design/anem_out_if.sv =====
interface anem_out_if;
    import anem_pkg::*;

    logic               valid;
    logic               ready;
    logic [MPH_W-1:0]   speed_mph;
    logic [RAW_W-1:0]   speed_raw_q8;
    logic [MPH_W-1:0]   gust_mph;
    logic [COUNT_W-1:0] pulse_count;
    logic [TIME_W-1:0]  last_period;
    logic               no_wind;

    modport source (
        output valid, output speed_mph, output speed_raw_q8, output gust_mph,
        output pulse_count, output last_period, output no_wind, input ready
    );
    modport sink (
        input valid, input speed_mph, input speed_raw_q8, input gust_mph,
        input pulse_count, input last_period, input no_wind, output ready
    );
endinterface

// ===== design/anem_cfg_if.sv =====
interface anem_cfg_if;
    import anem_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/anem_front.sv =====
module anem_front
    import anem_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    anem_in_if.sink          evt,
    input  logic [DEB_W-1:0] debounce_us,
    input  q_status_t        q_stat,
    output logic             push,
    output q_entry_t         push_data
);

    logic [TIME_W-1:0]  last_edge_reg, last_edge_next;
    logic [TIME_W-1:0]  last_pulse_reg, last_pulse_next;
    logic [TIME_W-1:0]  period_reg, period_next;
    logic [TIME_W-1:0]  win_start_reg, win_start_next;
    logic [COUNT_W-1:0] win_pulses_reg, win_pulses_next;

    logic              accept;
    logic [TIME_W-1:0] gap;
    logic              pulse_ok;

    assign evt.ready = !q_stat.full;
    assign accept    = evt.valid && evt.ready;
    assign gap       = evt.time_us - last_edge_reg;
    assign pulse_ok  = (last_pulse_reg != '0)
                       && (gap > {{(TIME_W-DEB_W){1'b0}}, debounce_us});

    always_comb
    begin
        last_edge_next  = last_edge_reg;
        last_pulse_next = last_pulse_reg;
        period_next     = period_reg;
        win_start_next  = win_start_reg;
        win_pulses_next = win_pulses_reg;
        push            = 1'b0;
        if (accept)
        begin
            case (evt.cmd)
                CMD_EDGE:
                begin
                    if (pulse_ok)
                    begin
                        period_next     = evt.time_us - last_pulse_reg;
                        last_pulse_next = evt.time_us;
                        if (win_pulses_reg != '1)
                        begin
                            win_pulses_next = win_pulses_reg + 1'b1;
                        end
                    end
                    last_edge_next = evt.time_us;
                    if (last_pulse_reg == '0)
                    begin
                        last_pulse_next = evt.time_us;
                    end
                    if (win_start_reg == '0)
                    begin
                        win_start_next = evt.time_us;
                    end
                end
                CMD_READ:
                begin
                    push            = 1'b1;
                    win_pulses_next = '0;
                    win_start_next  = '0;
                end
                CMD_GUST:
                begin
                    push = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        push_data.is_gust = (evt.cmd == CMD_GUST);
        push_data.per     = period_reg;
        push_data.cnt     = win_pulses_reg;
        push_data.span    = last_pulse_reg - win_start_reg;
        push_data.silence = evt.time_us - last_pulse_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_edge_reg  <= '0;
            last_pulse_reg <= '0;
            period_reg     <= TIMEOUT_RST;
            win_start_reg  <= '0;
            win_pulses_reg <= '0;
        end
        else
        begin
            last_edge_reg  <= last_edge_next;
            last_pulse_reg <= last_pulse_next;
            period_reg     <= period_next;
            win_start_reg  <= win_start_next;
            win_pulses_reg <= win_pulses_next;
        end
    end

endmodule

// ===== design/anem_fifo.sv =====
module anem_fifo
    import anem_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  q_entry_t  push_data,
    input  logic      pop,
    output q_entry_t  pop_data,
    output q_status_t q_stat
);

    q_entry_t             entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;

    assign q_stat.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign pop_data     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/anem_div.sv =====
module anem_div
    import anem_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [NUM_W-1:0]     quo_reg, quo_next;
    logic [TIME_W-1:0]    rem_reg, rem_next;
    logic [TIME_W-1:0]    den_reg, den_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [TIME_W:0] trial;
    logic [TIME_W:0] diff;
    logic            fits;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            den_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            if (cnt_reg == DIV_CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

endmodule

// ===== design/anem_back.sv =====
module anem_back
    import anem_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  q_status_t q_stat,
    input  q_entry_t  pop_data,
    output logic      pop,
    output div_req_t  div_req,
    input  div_rsp_t  div_rsp,
    anem_out_if.source result
);

    back_state_t state_reg, state_next;

    q_entry_t           ent_reg, ent_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic               nw_reg, nw_next;
    logic [MPH_W-1:0]   mph_reg, mph_next;
    logic [RAW_W-1:0]   raw_reg, raw_next;
    logic [MPH_W-1:0]   gust_reg, gust_next;

    logic               out_valid_reg, out_valid_next;
    logic [MPH_W-1:0]   out_mph_reg, out_mph_next;
    logic [RAW_W-1:0]   out_raw_reg, out_raw_next;
    logic [MPH_W-1:0]   out_gust_reg, out_gust_next;
    logic [COUNT_W-1:0] out_cnt_reg, out_cnt_next;
    logic [TIME_W-1:0]  out_per_reg, out_per_next;
    logic               out_nw_reg, out_nw_next;

    logic             out_free;
    logic             nowind;
    logic             use_avg;
    logic             avg_zero;
    logic [NUM_W:0]   mph_sum;
    logic [MPH_W-1:0] gust_max;
    logic [NUM_W-1:0] num_prod;

    assign out_free = !out_valid_reg || result.ready;
    assign nowind   = (ent_reg.per == '0) || (ent_reg.per >= cfg.timeout_us)
                      || (ent_reg.silence > cfg.timeout_us);
    assign use_avg  = (ent_reg.cnt >= cfg.avg_min_pulses)
                      && (ent_reg.cnt > COUNT_W'(1));
    assign avg_zero = (div_rsp.quotient[TIME_W-1:0] == '0);
    assign mph_sum  = {1'b0, div_rsp.quotient} + MPH_HALF;
    assign gust_max = (mph_reg > gust_reg) ? mph_reg : gust_reg;
    assign num_prod = NUM_W'(US_PER_S) * NUM_W'(cfg.mph_per_rps);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_stat.empty && !pop_data.is_gust)
                begin
                    state_next = B_MUL;
                end
            end
            B_MUL:
            begin
                if (nowind)
                begin
                    state_next = B_DONE;
                end
                else if (use_avg)
                begin
                    state_next = B_AVG;
                end
                else
                begin
                    state_next = B_QUO;
                end
            end
            B_AVG:
            begin
                if (div_rsp.done)
                begin
                    state_next = avg_zero ? B_DONE : B_QUO;
                end
            end
            B_QUO:
            begin
                if (div_rsp.done)
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop              = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = num_reg;
        div_req.divisor  = ent_reg.per;
        ent_next         = ent_reg;
        num_next         = num_reg;
        nw_next          = nw_reg;
        mph_next         = mph_reg;
        raw_next         = raw_reg;
        gust_next        = gust_reg;
        out_valid_next   = out_valid_reg;
        out_mph_next     = out_mph_reg;
        out_raw_next     = out_raw_reg;
        out_gust_next    = out_gust_reg;
        out_cnt_next     = out_cnt_reg;
        out_per_next     = out_per_reg;
        out_nw_next      = out_nw_reg;
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            B_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop      = 1'b1;
                    ent_next = pop_data;
                    num_next = num_prod;
                    if (pop_data.is_gust)
                    begin
                        gust_next = '0;
                    end
                end
            end
            B_MUL:
            begin
                nw_next  = nowind;
                mph_next = '0;
                raw_next = '0;
                if (!nowind)
                begin
                    div_req.start = 1'b1;
                    if (use_avg)
                    begin
                        div_req.dividend = {{(NUM_W-TIME_W){1'b0}}, ent_reg.span};
                        div_req.divisor  = {{(TIME_W-COUNT_W){1'b0}},
                                            ent_reg.cnt - COUNT_W'(1)};
                    end
                end
            end
            B_AVG:
            begin
                div_req.divisor = div_rsp.quotient[TIME_W-1:0];
                if (div_rsp.done)
                begin
                    if (avg_zero)
                    begin
                        mph_next = MPH_MAX;
                        raw_next = RAW_MAX;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                    end
                end
            end
            B_QUO:
            begin
                if (div_rsp.done)
                begin
                    raw_next = (|div_rsp.quotient[NUM_W-1:RAW_W+8])
                               ? RAW_MAX : div_rsp.quotient[RAW_W+7:8];
                    mph_next = (|mph_sum[NUM_W:MPH_W+16])
                               ? MPH_MAX : mph_sum[MPH_W+15:16];
                end
            end
            B_DONE:
            begin
                if (out_free)
                begin
                    gust_next      = gust_max;
                    out_valid_next = 1'b1;
                    out_mph_next   = mph_reg;
                    out_raw_next   = raw_reg;
                    out_gust_next  = gust_max;
                    out_cnt_next   = ent_reg.cnt;
                    out_per_next   = ent_reg.per;
                    out_nw_next    = nw_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign result.valid        = out_valid_reg;
    assign result.speed_mph    = out_mph_reg;
    assign result.speed_raw_q8 = out_raw_reg;
    assign result.gust_mph     = out_gust_reg;
    assign result.pulse_count  = out_cnt_reg;
    assign result.last_period  = out_per_reg;
    assign result.no_wind      = out_nw_reg;

    always_ff @(posedge clk)
    begin
        ent_reg      <= ent_next;
        num_reg      <= num_next;
        nw_reg       <= nw_next;
        mph_reg      <= mph_next;
        raw_reg      <= raw_next;
        out_mph_reg  <= out_mph_next;
        out_raw_reg  <= out_raw_next;
        out_gust_reg <= out_gust_next;
        out_cnt_reg  <= out_cnt_next;
        out_per_reg  <= out_per_next;
        out_nw_reg   <= out_nw_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            gust_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gust_reg      <= gust_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== design/anemometer_pulse_wind_speed_unit.sv =====
// Cup anemometer wind speed from timestamped events. The front end takes a
// switch edge, read or gust reset whenever the queue is not full; edges update
// the period and pulse window there at once, while reads and gust resets wait
// in a two-entry queue for the back end. Reads are computed by the bit-serial
// divider that produces one quotient bit per cycle over 44 steps (once for the
// mean period on an averaged read, once for the speed); a read that hits the
// no-wind rule skips the divider. The result register lets the back end finish
// the next read while a result waits. Configuration writes are registered and
// are always ready.
module anemometer_pulse_wind_speed_unit
    import anem_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    anem_in_if.sink    evt,
    anem_out_if.source result,
    anem_cfg_if.sink   cfg
);

    cfg_t      cfg_reg, cfg_next;
    q_status_t q_stat;
    logic      push;
    q_entry_t  push_data;
    logic      pop;
    q_entry_t  pop_data;
    div_req_t  div_req;
    div_rsp_t  div_rsp;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_DEBOUNCE:  cfg_next.debounce_us    = cfg.data[DEB_W-1:0];
                REG_TIMEOUT:   cfg_next.timeout_us     = cfg.data[TIME_W-1:0];
                REG_MIN_COUNT: cfg_next.avg_min_pulses = cfg.data[MIN_W-1:0];
                REG_MPH_RPS:   cfg_next.mph_per_rps    = cfg.data[MPR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_us    <= DEBOUNCE_RST;
            cfg_reg.timeout_us     <= TIMEOUT_RST;
            cfg_reg.avg_min_pulses <= MIN_COUNT_RST;
            cfg_reg.mph_per_rps    <= MPH_RPS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    anem_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .evt         (evt),
        .debounce_us (cfg_reg.debounce_us),
        .q_stat      (q_stat),
        .push        (push),
        .push_data   (push_data)
    );

    anem_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    anem_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    anem_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_stat   (q_stat),
        .pop_data (pop_data),
        .pop      (pop),
        .div_req  (div_req),
        .div_rsp  (div_rsp),
        .result   (result)
    );

    a_nowind_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.no_wind |->
            result.speed_mph == '0 && result.speed_raw_q8 == '0)
        else $error("no-wind result carries a nonzero speed");

    a_gust_peak: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.gust_mph >= result.speed_mph)
        else $error("gust below reported speed");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !evt.ready)
        else $error("input ready while queue is full");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("queue popped while empty");

endmodule

// ===== tb/testbench.sv =====
module testbench;
    import anem_pkg::*;

    localparam logic [1:0] CMD_NOP      = 2'd3;
    localparam int         STALL_LIMIT  = 10000;
    localparam int         DRAIN_CYCLES = 400;
    localparam int         DRILL_ROWS   = 29;
    localparam int         PHASES       = 8;
    localparam int         PHASE_ITEMS  = 250;

    typedef struct packed {
        logic [MPH_W-1:0]   mph;
        logic [RAW_W-1:0]   raw;
        logic [MPH_W-1:0]   gust;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  period;
        logic               calm;
    } wind_report_t;

    typedef enum {STEP_EVT, STEP_CFG} step_kind_t;
    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct {
        step_kind_t             kind;
        logic [CFG_IDX_W-1:0]   code;
        logic [CFG_DATA_W-1:0]  value;
        bit                     typed;
        wind_report_t           want;
    } drill_row_t;

    logic clk = 1'b0;
    logic rst_n;

    anem_in_if  evt();
    anem_out_if result();
    anem_cfg_if cfg();

    anemometer_pulse_wind_speed_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .evt    (evt),
        .result (result),
        .cfg    (cfg)
    );

    always #5 clk = ~clk;

    logic [DEB_W-1:0]   debounce_lim;
    logic [TIME_W-1:0]  calm_limit;
    logic [MIN_W-1:0]   avg_from;
    logic [MPR_W-1:0]   mph_gain;
    logic [TIME_W-1:0]  edge_seen_at;
    logic [TIME_W-1:0]  pulse_seen_at;
    logic [TIME_W-1:0]  rot_period;
    logic [TIME_W-1:0]  window_open_at;
    logic [COUNT_W-1:0] window_count;
    logic [MPH_W-1:0]   gust_hold;

    wind_report_t pending_reports[$];
    drill_row_t   drill [DRILL_ROWS];
    logic [TIME_W-1:0] wall_us;
    int send_idle_pct;
    int recv_stall_pct;
    int mismatch_count;
    int quiet_cycles;

    function automatic bit step_anemometer(input logic [1:0] cmd, input logic [TIME_W-1:0] t,
                                           output wind_report_t rep);
        logic [TIME_W-1:0]  gap;
        logic [TIME_W-1:0]  span;
        logic [TIME_W-1:0]  per_snap;
        logic [TIME_W-1:0]  lp_snap;
        logic [TIME_W-1:0]  ws_snap;
        logic [COUNT_W-1:0] cnt_snap;
        longint unsigned    p;
        longint unsigned    num;
        longint unsigned    mph;
        longint unsigned    raw;
        rep = '0;
        mph = 0;
        raw = 0;
        case (cmd)
            CMD_EDGE:
            begin
                gap = t - edge_seen_at;
                if (pulse_seen_at != '0 && gap > debounce_lim)
                begin
                    rot_period    = t - pulse_seen_at;
                    pulse_seen_at = t;
                    if (window_count != '1)
                        window_count = window_count + 1'b1;
                end
                edge_seen_at = t;
                if (pulse_seen_at == '0)
                    pulse_seen_at = t;
                if (window_open_at == '0)
                    window_open_at = t;
                return 1'b0;
            end
            CMD_READ:
            begin
                per_snap       = rot_period;
                lp_snap        = pulse_seen_at;
                ws_snap        = window_open_at;
                cnt_snap       = window_count;
                window_count   = '0;
                window_open_at = '0;
                gap            = t - lp_snap;
                if (per_snap == '0 || per_snap >= calm_limit || gap > calm_limit)
                    rep.calm = 1'b1;
                else
                begin
                    p   = per_snap;
                    num = 64'd1000000 * mph_gain;
                    if (cnt_snap >= avg_from && cnt_snap > 1)
                    begin
                        span = lp_snap - ws_snap;
                        p    = span / (cnt_snap - 1);
                    end
                    if (p == 0)
                    begin
                        mph = 255;
                        raw = 65535;
                    end
                    else if (p <= num)
                    begin
                        raw = num / (p * 256);
                        if (raw > 65535)
                            raw = 65535;
                        mph = (num + p * 32768) / (p * 65536);
                        if (mph > 255)
                            mph = 255;
                    end
                    if (mph > gust_hold)
                        gust_hold = MPH_W'(mph);
                end
                rep.mph    = MPH_W'(mph);
                rep.raw    = RAW_W'(raw);
                rep.gust   = gust_hold;
                rep.count  = cnt_snap;
                rep.period = per_snap;
                return 1'b1;
            end
            CMD_GUST:
            begin
                gust_hold = '0;
                return 1'b0;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 88; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 88; end
            default:   begin send_idle_pct = 10; recv_stall_pct = 10; end
        endcase
    endtask

    task automatic send_evt(input logic [1:0] cmd, input logic [TIME_W-1:0] t,
                            input bit typed, input wind_report_t want);
        wind_report_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            evt.valid <= 1'b0;
        end
        @(negedge clk);
        evt.valid   <= 1'b1;
        evt.cmd     <= cmd;
        evt.time_us <= t;
        do
            @(posedge clk);
        while (evt.ready !== 1'b1);
        if (step_anemometer(cmd, t, predicted))
            pending_reports.push_back(typed ? want : predicted);
    endtask

    task automatic wait_quiet();
        @(negedge clk);
        evt.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do
            @(posedge clk);
        while (cfg.ready !== 1'b1);
        case (idx)
            REG_DEBOUNCE:  debounce_lim = data[DEB_W-1:0];
            REG_TIMEOUT:   calm_limit   = data[TIME_W-1:0];
            REG_MIN_COUNT: avg_from     = data[MIN_W-1:0];
            REG_MPH_RPS:   mph_gain     = data[MPR_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic configure(input logic [DEB_W-1:0] deb, input logic [TIME_W-1:0] tmo,
                             input logic [MIN_W-1:0] mn, input logic [MPR_W-1:0] mpr);
        wait_quiet();
        write_reg(REG_DEBOUNCE, CFG_DATA_W'(deb));
        write_reg(REG_TIMEOUT, CFG_DATA_W'(tmo));
        write_reg(REG_MIN_COUNT, CFG_DATA_W'(mn));
        write_reg(REG_MPH_RPS, CFG_DATA_W'(mpr));
    endtask

    task automatic random_phase(input int n_items);
        int sent;
        int run_len;
        logic [1:0] c;
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] per;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(9) == 0)
            begin
                // noise: any code, any time, sometimes time zero
                c = 2'($urandom_range(3));
                t = ($urandom_range(3) == 0) ? '0 : $urandom();
                if ($urandom_range(1) == 1)
                    wall_us = t;
                send_evt(c, t, 1'b0, '0);
                if (c != CMD_NOP)
                    sent++;
            end
            else
            begin
                if ($urandom_range(7) == 0)
                    wall_us = 32'hFFFF_FFFF - $urandom_range(1 << 24);
                per     = $urandom_range(1 << $urandom_range(24, 4), 1);
                run_len = $urandom_range(12, 2);
                repeat (run_len)
                begin
                    wall_us = wall_us + per + $urandom_range(per >> 4);
                    send_evt(CMD_EDGE, wall_us, 1'b0, '0);
                    sent++;
                    if ($urandom_range(4) == 0)
                    begin
                        send_evt(CMD_EDGE, wall_us + $urandom_range(debounce_lim), 1'b0, '0);
                        sent++;
                    end
                    if ($urandom_range(4) == 0)
                    begin
                        send_evt(CMD_READ, wall_us + $urandom_range(per), 1'b0, '0);
                        sent++;
                    end
                    if ($urandom_range(29) == 0)
                    begin
                        send_evt(CMD_GUST, wall_us, 1'b0, '0);
                        sent++;
                    end
                end
                // long silence now and then
                if ($urandom_range(5) == 0)
                    wall_us = wall_us + (32'd1 << $urandom_range(31, 16));
                send_evt(CMD_READ, wall_us + $urandom_range(per), 1'b0, '0);
                sent++;
            end
        end
    endtask

    always @(negedge clk)
        result.ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin : report_check
        wind_report_t want;
        if (rst_n === 1'b1 && result.valid === 1'b1 && result.ready === 1'b1)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("unexpected wind report beat");
                mismatch_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                if (result.speed_mph !== want.mph)
                begin
                    $error("speed_mph: expected %0d, got %0d", want.mph, result.speed_mph);
                    mismatch_count++;
                end
                if (result.speed_raw_q8 !== want.raw)
                begin
                    $error("speed_raw_q8: expected %0d, got %0d", want.raw, result.speed_raw_q8);
                    mismatch_count++;
                end
                if (result.gust_mph !== want.gust)
                begin
                    $error("gust_mph: expected %0d, got %0d", want.gust, result.gust_mph);
                    mismatch_count++;
                end
                if (result.pulse_count !== want.count)
                begin
                    $error("pulse_count: expected %0d, got %0d", want.count, result.pulse_count);
                    mismatch_count++;
                end
                if (result.last_period !== want.period)
                begin
                    $error("last_period: expected %0d, got %0d", want.period, result.last_period);
                    mismatch_count++;
                end
                if (result.no_wind !== want.calm)
                begin
                    $error("no_wind: expected %0d, got %0d", want.calm, result.no_wind);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((evt.valid === 1'b1 && evt.ready === 1'b1)
            || (result.valid === 1'b1 && result.ready === 1'b1)
            || (cfg.valid === 1'b1 && cfg.ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        evt.valid      = 1'b0;
        evt.cmd        = CMD_EDGE;
        evt.time_us    = '0;
        cfg.valid      = 1'b0;
        cfg.index      = REG_DEBOUNCE;
        cfg.data       = '0;
        result.ready   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        wall_us        = 32'd40000000;

        debounce_lim   = 20'd5000;
        calm_limit     = 32'd10000000;
        avg_from       = 16'd3;
        mph_gain       = 24'd147456;
        edge_seen_at   = '0;
        pulse_seen_at  = '0;
        rot_period     = 32'd10000000;
        window_open_at = '0;
        window_count   = '0;
        gust_hold      = '0;

        drill = '{
            '{STEP_EVT, CMD_READ, 32'd100, 1'b1,
              '{8'd0, 16'd0, 8'd0, 16'd0, 32'd10000000, 1'b1}},
            '{STEP_EVT, CMD_EDGE, 32'd0, 1'b0, '0},
            '{STEP_EVT, CMD_EDGE, 32'd1000, 1'b0, '0},
            '{STEP_EVT, CMD_EDGE, 32'd3000, 1'b0, '0},
            '{STEP_EVT, CMD_EDGE, 32'd501000, 1'b0, '0},
            '{STEP_EVT, CMD_READ, 32'd502000, 1'b0, '0},
            '{STEP_EVT, CMD_GUST, 32'd503000, 1'b0, '0},
            '{STEP_EVT, CMD_EDGE, 32'd600000, 1'b0, '0},
            '{STEP_EVT, CMD_EDGE, 32'd700000, 1'b0, '0},
            '{STEP_EVT, CMD_EDGE, 32'd800000, 1'b0, '0},
            '{STEP_EVT, CMD_READ, 32'd800500, 1'b0, '0},
            '{STEP_EVT, CMD_NOP, 32'd900000, 1'b0, '0},
            '{STEP_EVT, CMD_READ, 32'd20000000, 1'b0, '0},
            '{STEP_EVT, CMD_EDGE, 32'd20100000, 1'b0, '0},
            '{STEP_EVT, CMD_EDGE, 32'd20101000, 1'b0, '0},
            '{STEP_EVT, CMD_EDGE, 32'd20100000, 1'b0, '0},
            '{STEP_EVT, CMD_READ, 32'd20100500, 1'b0, '0},
            '{STEP_CFG, REG_TIMEOUT, 32'hFFFF_FFFF, 1'b0, '0},
            '{STEP_CFG, REG_DEBOUNCE, 32'd0, 1'b0, '0},
            '{STEP_CFG, REG_MIN_COUNT, 32'd2, 1'b0, '0},
            '{STEP_CFG, REG_MPH_RPS, 32'h00FF_FFFF, 1'b0, '0},
            '{STEP_EVT, CMD_EDGE, 32'd30000000, 1'b0, '0},
            '{STEP_EVT, CMD_EDGE, 32'd30000005, 1'b0, '0},
            '{STEP_EVT, CMD_EDGE, 32'd30000000, 1'b0, '0},
            '{STEP_EVT, CMD_READ, 32'd30000001, 1'b1,
              '{8'd255, 16'd65535, 8'd255, 16'd3, 32'hFFFF_FFFB, 1'b0}},
            '{STEP_EVT, CMD_GUST, 32'hFFFF_FFFF, 1'b0, '0},
            '{STEP_EVT, CMD_EDGE, 32'hFFFF_FFFF, 1'b0, '0},
            '{STEP_CFG, REG_MPH_RPS, 32'd0, 1'b0, '0},
            '{STEP_EVT, CMD_READ, 32'hFFFF_FFFF, 1'b0, '0}
        };

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_idle(IDLE_NONE);
        for (int i = 0; i < DRILL_ROWS; i++)
        begin
            if (drill[i].kind == STEP_CFG)
            begin
                wait_quiet();
                write_reg(drill[i].code, drill[i].value);
            end
            else
                send_evt(drill[i].code[1:0], drill[i].value, drill[i].typed, drill[i].want);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: configure(20'd5000, 32'd10000000, 16'd3, 24'd147456);
                1: configure(20'd0, 32'hFFFF_FFFF, 16'd0, 24'hFF_FFFF);
                2: configure(20'd1000000, 32'd1, 16'hFFFF, 24'd0);
                default:
                    configure(DEB_W'($urandom_range(30000)),
                              TIME_W'($urandom_range(32'hFFFF_FFFF, 50000)),
                              MIN_W'($urandom_range(6)),
                              MPR_W'($urandom_range(24'hFF_FFFF)));
            endcase
            set_idle(idle_mode_t'(ph % 4));
            random_phase(PHASE_ITEMS);
        end

        wait_quiet();
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
